// ===== sv/lpdrs_pkg.sv =====
// Shared types, constants and helper functions for the LED panel digit row serialiser.
// Holds the font table, the beat structs and the controller/datapath link structs.
// No dependencies.
package lpdrs_pkg;

  typedef struct packed {
    logic [3:0] digit0;
    logic [3:0] digit1;
    logic [3:0] digit2;
    logic [3:0] digit3;
    logic       colon_dots;
    logic       date_dots;
    logic       shift_out;
  } in_t;

  typedef struct packed {
    logic [1:0] row;
    logic [7:0] line1_levels;
    logic [7:0] line2_levels;
    logic [7:0] line3_levels;
    logic       last;
  } out_t;

  // panel_layout codes
  localparam logic [1:0] LAYOUT_SINGLE = 2'd0;
  localparam logic [1:0] LAYOUT_DUAL   = 2'd1;
  localparam logic [1:0] LAYOUT_TRIPLE = 2'd2;

  // last word index per tick, per layout
  localparam logic [5:0] LAST_SINGLE = 6'd15;
  localparam logic [5:0] LAST_DUAL   = 6'd31;
  localparam logic [5:0] LAST_TRIPLE = 6'd63;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       emit;
    logic [5:0] word;
    logic       last;
    logic       advance;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       has_words;
    logic [5:0] last_idx;
    logic       out_free;
  } status_t;

  typedef logic [7:0] glyph_t [16];

  // 14 glyphs; codes 14 and 15 padded blank
  localparam glyph_t FONT [16] = '{
    '{8'h00,8'h00,8'h3C,8'h7E,8'h66,8'h66,8'h66,8'h66,
      8'h66,8'h66,8'h66,8'h66,8'h7E,8'h3C,8'h00,8'h00},
    '{8'h00,8'h00,8'h7E,8'h7E,8'h18,8'h18,8'h18,8'h18,
      8'h18,8'h18,8'h18,8'h78,8'h38,8'h18,8'h00,8'h00},
    '{8'h00,8'h00,8'h3C,8'h7E,8'h60,8'h60,8'h60,8'h7E,
      8'h7E,8'h06,8'h06,8'h06,8'h7E,8'h3C,8'h00,8'h00},
    '{8'h00,8'h00,8'h3C,8'h7E,8'h46,8'h06,8'h06,8'h3E,
      8'h3E,8'h06,8'h06,8'h46,8'h7E,8'h3C,8'h00,8'h00},
    '{8'h00,8'h00,8'h06,8'h06,8'h06,8'h06,8'h06,8'h7E,
      8'h7E,8'h66,8'h66,8'h66,8'h66,8'h66,8'h00,8'h00},
    '{8'h00,8'h00,8'h3C,8'h7E,8'h66,8'h06,8'h06,8'h7E,
      8'h7C,8'h60,8'h60,8'h60,8'h7E,8'h7E,8'h00,8'h00},
    '{8'h00,8'h00,8'h3C,8'h7E,8'h66,8'h66,8'h66,8'h7E,
      8'h7C,8'h60,8'h60,8'h66,8'h7E,8'h3C,8'h00,8'h00},
    '{8'h00,8'h00,8'h30,8'h30,8'h30,8'h30,8'h30,8'h30,
      8'h18,8'h0C,8'h06,8'h06,8'h7E,8'h7E,8'h00,8'h00},
    '{8'h00,8'h00,8'h3C,8'h7E,8'h66,8'h66,8'h66,8'h3C,
      8'h3C,8'h66,8'h66,8'h66,8'h7E,8'h3C,8'h00,8'h00},
    '{8'h00,8'h00,8'h3C,8'h7E,8'h66,8'h06,8'h06,8'h3E,
      8'h7E,8'h66,8'h66,8'h66,8'h7E,8'h3C,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h3C,8'h66,8'h66,8'h66,8'h3C,8'h00,8'h00},
    '{8'h00,8'h00,8'h1C,8'h3E,8'h72,8'h60,8'h60,8'h60,
      8'h60,8'h60,8'h60,8'h72,8'h3E,8'h1C,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h7E,
      8'h7E,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
  };

  // Glyph row with shift and dot overlay applied.
  function automatic logic [7:0] glyph_row(logic [3:0] code, logic [3:0] r,
                                           logic [1:0] dig, logic shift,
                                           logic colon, logic date);
    logic [7:0] b;
    logic [7:0] dot;
    b   = FONT[code][r];
    dot = (dig == 2'd1) ? 8'h01 : 8'h80;
    if (shift) begin
      b = dig[1] ? (b >> 1) : (b << 1);
    end
    if (dig == 2'd1 || dig == 2'd2) begin
      if (colon && (r == 4'd5 || r == 4'd6 || r == 4'd9 || r == 4'd10)) begin
        b = b | dot;
      end
      if (date && (r == 4'd2 || r == 4'd3)) begin
        b = b | dot;
      end
    end
    return b;
  endfunction

  // Inverted serial levels: clock c takes bit (7 - off - c/2^rep_sh) of d.
  function automatic logic [7:0] spread(logic [7:0] d, logic [2:0] off,
                                        logic [1:0] rep_sh);
    logic [7:0] lv;
    logic [2:0] src;
    logic [2:0] cc;
    lv = '0;
    for (int c = 0; c < 8; c++) begin
      cc  = 3'(c);
      src = 3'd7 - off - (cc >> rep_sh);
      lv[3'd7 - cc] = ~d[src];
    end
    return lv;
  endfunction

endpackage

// ===== sv/lpdrs_ctrl.sv =====
// Sequencer for the LED panel digit row serialiser: accepts a beat, then steps
// the word index once per free output slot. Depends on lpdrs_pkg.
module lpdrs_ctrl
  import lpdrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t     state;
  logic [5:0] word;
  logic       accept;

  assign item_stall  = (state != IDLE);
  assign accept      = item_valid && (state == IDLE);

  assign cmd.load    = accept;
  assign cmd.emit    = (state == RUN) && st.out_free;
  assign cmd.word    = word;
  assign cmd.last    = (word == st.last_idx);
  assign cmd.advance = (accept && !st.has_words) || (cmd.emit && cmd.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      word  <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          word <= '0;
          if (accept && st.has_words) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (cmd.emit) begin
            if (cmd.last) begin
              state <= IDLE;
            end else begin
              word <= word + 6'd1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== sv/lpdrs_dpath.sv =====
// Datapath for the LED panel digit row serialiser: payload capture, row counter,
// held line levels, glyph lookup, level spreading and the result register.
// Depends on lpdrs_pkg.
module lpdrs_dpath
  import lpdrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  in_t        item,
  input  cmd_t       cmd,
  output status_t    st,
  input  logic       result_stall,
  output logic       result_valid,
  output out_t       result
);

  logic [1:0] layout;
  logic [1:0] row;
  logic       held2;
  logic       held3;
  in_t        cur;

  logic [1:0] dig;
  logic [1:0] pass;
  logic [1:0] idx;
  logic [3:0] r1, r2, r3;
  logic [3:0] code;
  logic [2:0] off;
  logic [1:0] rep_sh;
  logic [7:0] g1, g2, g3;
  logic [7:0] l1, l2, l3;
  logic [3:0] j3;

  // word count for the current row
  always_comb begin
    unique case (layout)
      LAYOUT_SINGLE: begin
        st.has_words = 1'b1;
        st.last_idx  = LAST_SINGLE;
      end
      LAYOUT_DUAL: begin
        st.has_words = !row[0];
        st.last_idx  = LAST_DUAL;
      end
      LAYOUT_TRIPLE: begin
        st.has_words = (row == 2'd0);
        st.last_idx  = LAST_TRIPLE;
      end
      default: begin
        st.has_words = 1'b0;
        st.last_idx  = LAST_SINGLE;
      end
    endcase
  end
  assign st.out_free = !result_valid || !result_stall;

  // word index -> digit, pass, glyph rows
  always_comb begin
    idx    = cmd.word[1:0];
    j3     = {2'b00, idx} + 4'd2;
    dig    = cmd.word[3:2];
    pass   = 2'd0;
    off    = 3'd0;
    rep_sh = 2'd0;
    r1     = {idx, 2'b11} - {2'b00, row};
    r2     = r1;
    r3     = r1;
    unique case (layout)
      LAYOUT_DUAL: begin
        dig    = cmd.word[4:3];
        pass   = {1'b0, cmd.word[2]};
        off    = {pass[0], 2'b00};
        rep_sh = 2'd1;
        r1     = {1'b1, idx, 1'b1} - {3'b000, row[1]};
        r2     = {1'b0, idx, 1'b1} - {3'b000, row[1]};
      end
      LAYOUT_TRIPLE: begin
        dig    = cmd.word[5:4];
        pass   = cmd.word[3:2];
        off    = {pass, 1'b0};
        rep_sh = 2'd2;
        r1     = j3 + 4'd8;
        r2     = j3 + 4'd4;
        r3     = j3;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (dig)
      2'd0:    code = cur.digit0;
      2'd1:    code = cur.digit1;
      2'd2:    code = cur.digit2;
      default: code = cur.digit3;
    endcase
  end

  assign g1 = glyph_row(code, r1, dig, cur.shift_out, cur.colon_dots, cur.date_dots);
  assign g2 = glyph_row(code, r2, dig, cur.shift_out, cur.colon_dots, cur.date_dots);
  assign g3 = glyph_row(code, r3, dig, cur.shift_out, cur.colon_dots, cur.date_dots);

  assign l1 = spread(g1, off, rep_sh);
  assign l2 = (layout == LAYOUT_SINGLE) ? {8{held2}} : spread(g2, off, rep_sh);
  assign l3 = (layout == LAYOUT_TRIPLE) ? spread(g3, off, rep_sh) : {8{held3}};

  always_ff @(posedge clk) begin
    if (rst) begin
      layout       <= LAYOUT_SINGLE;
      row          <= '0;
      held2        <= 1'b0;
      held3        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        layout <= cfg_wdata;
      end
      if (cmd.advance) begin
        row <= row + 2'd1;
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
        if (layout != LAYOUT_SINGLE) begin
          held2 <= l2[0];
        end
        if (layout == LAYOUT_TRIPLE) begin
          held3 <= l3[0];
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
    if (cmd.emit) begin
      result.row          <= row;
      result.line1_levels <= l1;
      result.line2_levels <= l2;
      result.line3_levels <= l3;
      result.last         <= cmd.last;
    end
  end

endmodule

// ===== sv/led_panel_digit_row_serializer.sv =====
// LED panel digit row serialiser, top level.
// The first word is registered after the payload capture of the item beat.
// New items wait while busy; one word per cycle while the result is free,
// 16, 32 or 64 words in layouts 0/1/2; a row with no words emits none.
// Reset (rst, synchronous): row 0, layout 0, held line levels low, no result.
module led_panel_digit_row_serializer
  import lpdrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       item_valid,
  output logic       item_stall,
  input  in_t        item,
  output logic       result_valid,
  input  logic       result_stall,
  output out_t       result
);

  // Controller walks the word index of a tick; the datapath turns each index
  // into a digit, pass and up to three glyph rows and latches one word.
  cmd_t    cmd;
  status_t st;

  lpdrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  // Result register parts the two sides: a new item beat is taken while the
  // last word of the previous tick still waits.
  lpdrs_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item         (item),
    .cmd          (cmd),
    .st           (st),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== sv/lpdrs_checker.sv =====
// Port-level checks for the LED panel digit row serialiser, bound to the top.
// Depends on lpdrs_pkg.
module lpdrs_checker
  import lpdrs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input out_t       result
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // busy only after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(item_stall) |-> $past(item_valid))
    else $error("stall rose without an item beat");

  // line 2 levels come in repeated pairs in every layout
  a_line2: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.line2_levels[7] == result.line2_levels[6]) &&
                     (result.line2_levels[5] == result.line2_levels[4]) &&
                     (result.line2_levels[3] == result.line2_levels[2]) &&
                     (result.line2_levels[1] == result.line2_levels[0]))
    else $error("line 2 levels not repeated");

  // line 3 levels come in repeated nibbles in every layout
  a_line3: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.line3_levels[7:4] == 4'h0 ||
                      result.line3_levels[7:4] == 4'hF) &&
                     (result.line3_levels[3:0] == 4'h0 ||
                      result.line3_levels[3:0] == 4'hF))
    else $error("line 3 levels not repeated");

endmodule

bind led_panel_digit_row_serializer lpdrs_checker u_chk (.*);
